[hw/rtl/chained_xor_packet_decrypt_defines.svh]
// ----------------------------------------------------------------------------
// Chained XOR packet decrypt: assertion macros
// Concurrent assertion wrappers. They compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef CHAINED_XOR_PACKET_DECRYPT_DEFINES_SVH
`define CHAINED_XOR_PACKET_DECRYPT_DEFINES_SVH

`ifndef SYNTH
// Checked only while out of reset.
`define CXPD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every edge, reset included.
`define CXPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CXPD_ASSERT(lbl, clk, rstn, prop, msg)
`define CXPD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[hw/rtl/cxpd_pkg.sv]
// ----------------------------------------------------------------------------
// Chained XOR packet decrypt package
// Shared transaction types and reset constants.
// ----------------------------------------------------------------------------
package cxpd_pkg;

  localparam logic [7:0] PrivateKeyReset = 8'h00;
  localparam logic [7:0] FirstPosition   = 8'h01;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic [7:0] random_key;
    logic       first_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       is_checksum;
    logic       is_last;
    logic       checksum_ok;
  } result_t;

endpackage

[hw/rtl/cxpd_in_reg.sv]
// ----------------------------------------------------------------------------
// Chained XOR packet decrypt: input register
// Captures one input transaction and holds it until the decrypt stage advances.
// ----------------------------------------------------------------------------
module cxpd_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cxpd_pkg::item_t in_item_i,
  input  logic            advance_i,
  output logic            valid_o,
  output cxpd_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  cxpd_pkg::item_t item_q;

  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset; load on every accepted transaction.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[hw/rtl/cxpd_decrypt.sv]
// ----------------------------------------------------------------------------
// Chained XOR packet decrypt: decrypt stage
// Two chained XOR layers, chain state, payload sum and private key register.
// ----------------------------------------------------------------------------
module cxpd_decrypt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              advance_i,
  input  cxpd_pkg::item_t   item_i,
  output cxpd_pkg::result_t result_o
);

  logic [7:0] key_q;
  logic [7:0] prev_cipher_q, prev_cipher_d;
  logic [7:0] prev_plain_q, prev_plain_d;
  logic [7:0] pos_q, pos_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] chk_q, chk_d;
  logic [7:0] mid;
  logic [7:0] plain;

  always_comb begin
    // A packet start restarts the chain at position one.
    if (item_i.first_byte) begin
      pos_d = cxpd_pkg::FirstPosition;
    end else begin
      pos_d = pos_q + 8'd1;
    end
    mid   = item_i.cipher_byte
          ^ ((item_i.first_byte ? 8'h00 : prev_cipher_q) + key_q + pos_d);
    plain = mid ^ ((item_i.first_byte ? 8'h00 : prev_plain_q) + item_i.random_key + pos_d);
    prev_cipher_d = item_i.cipher_byte;
    prev_plain_d  = mid;
    if (item_i.first_byte) begin
      sum_d = 8'h00;
      chk_d = plain;
    end else begin
      sum_d = sum_q + plain;
      chk_d = chk_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q         <= cxpd_pkg::PrivateKeyReset;
      prev_cipher_q <= 8'h00;
      prev_plain_q  <= 8'h00;
      pos_q         <= 8'h00;
      sum_q         <= 8'h00;
      chk_q         <= 8'h00;
    end else begin
      if (cfg_we_i) begin
        key_q <= cfg_wdata_i;
      end
      if (advance_i) begin
        prev_cipher_q <= prev_cipher_d;
        prev_plain_q  <= prev_plain_d;
        pos_q         <= pos_d;
        sum_q         <= sum_d;
        chk_q         <= chk_d;
      end
    end
  end

  assign result_o.plain_byte  = plain;
  assign result_o.is_checksum = item_i.first_byte;
  assign result_o.is_last     = item_i.last_byte;
  assign result_o.checksum_ok = item_i.last_byte && (sum_d == chk_d);

endmodule

[hw/rtl/chained_xor_packet_decrypt.sv]
// ----------------------------------------------------------------------------
// Chained XOR packet decrypt: top level
// Path from input acceptance to result valid: input register, then result
//   register; throughput 1 byte per cycle while the result side does not stall,
//   set by the two-layer add-and-XOR pass from input to result register.
// Reset: asynchronous active low; clears the chain, position, sum, checksum
//   and private key to zero and empties both register stages.
// ----------------------------------------------------------------------------
`include "chained_xor_packet_decrypt_defines.svh"

module chained_xor_packet_decrypt (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration: private key
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  // input channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] cipher_byte_i,
  input  logic [7:0] random_key_i,
  input  logic       first_byte_i,
  input  logic       last_byte_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] plain_byte_o,
  output logic       is_checksum_o,
  output logic       is_last_o,
  output logic       checksum_ok_o
);

  cxpd_pkg::item_t   in_item;
  cxpd_pkg::item_t   stage_item;
  cxpd_pkg::result_t stage_result;
  cxpd_pkg::result_t result_q;
  logic              stage_valid;
  logic              advance;
  logic              out_valid_q, out_valid_d;

  assign in_item.cipher_byte = cipher_byte_i;
  assign in_item.random_key  = random_key_i;
  assign in_item.first_byte  = first_byte_i;
  assign in_item.last_byte   = last_byte_i;

  // Advance the held transaction whenever the result register is free or
  // being drained this cycle; the chain state moves with it.
  assign advance = stage_valid && (!out_valid_q || out_ready_i);

  cxpd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  cxpd_decrypt u_decrypt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (advance),
    .item_i      (stage_item),
    .result_o    (stage_result)
  );

  // Result register: load on advance, drop valid once taken.
  assign out_valid_d = advance ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= stage_result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign plain_byte_o  = result_q.plain_byte;
  assign is_checksum_o = result_q.is_checksum;
  assign is_last_o     = result_q.is_last;
  assign checksum_ok_o = result_q.checksum_ok;

  // An advanced transaction always shows up as a valid result.
  `CXPD_ASSERT(a_advance_fills_out, clk_i, rst_ni, advance |=> out_valid_o, "advance lost result")
  // A held transaction stays held while the result side stalls.
  `CXPD_ASSERT(a_stage_holds, clk_i, rst_ni, stage_valid && !advance |=> stage_valid, "stage item dropped")
  // Backpressure on the input only when a transaction is parked.
  `CXPD_ASSERT_ALWAYS(a_ready_when_empty, clk_i, !in_ready_o |-> stage_valid, "stall while empty")
  // An empty-payload packet passes exactly when its checksum is zero.
  `CXPD_ASSERT(a_empty_packet_check, clk_i, rst_ni, out_valid_o && is_checksum_o && is_last_o |-> checksum_ok_o == (plain_byte_o == 8'h00), "empty packet check wrong")

endmodule

[dv/tb_chained_xor_packet_decrypt.sv]
// ----------------------------------------------------------------------------
// Chained XOR packet decrypt: testbench
// Drives encrypted packet regions into the decryptor under random flow
// control on both channels. Each result is compared field by field against
// an in-bench model of the two-layer XOR chain and the payload sum check.
// The private key is changed between phases.
// ----------------------------------------------------------------------------
module tb_chained_xor_packet_decrypt;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned DrainLimit   = 20000;
  localparam int unsigned PhaseItems   = 240;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned SettleCycles = 8;

  // Model of the decryptor: holds its own chain state and key, and queues
  // the plain-byte result for every accepted cipher byte.
  class decrypt_predictor;
    logic [7:0] key;
    logic [7:0] last_cipher;
    logic [7:0] last_mid;
    logic [7:0] pos;
    logic [7:0] body_sum;
    logic [7:0] check_byte;
    cxpd_pkg::result_t expected_plain_q[$];
    int unsigned errors;
    int unsigned results_seen;
    int unsigned starts_seen;
    int unsigned sums_matched;
    int unsigned sums_missed;

    function new();
      key          = cxpd_pkg::PrivateKeyReset;
      last_cipher  = '0;
      last_mid     = '0;
      pos          = '0;
      body_sum     = '0;
      check_byte   = '0;
      errors       = 0;
      results_seen = 0;
      starts_seen  = 0;
      sums_matched = 0;
      sums_missed  = 0;
    endfunction

    function void set_key(logic [7:0] k);
      key = k;
    endfunction

    function void note_cipher(cxpd_pkg::item_t it);
      logic [7:0] mid;
      logic [7:0] plain;
      cxpd_pkg::result_t r;
      if (it.first_byte) begin
        pos         = cxpd_pkg::FirstPosition;
        last_cipher = '0;
        last_mid    = '0;
        body_sum    = '0;
        starts_seen++;
      end else begin
        pos = pos + 8'd1;
      end
      mid         = it.cipher_byte ^ (last_cipher + key + pos);
      plain       = mid ^ (last_mid + it.random_key + pos);
      last_cipher = it.cipher_byte;
      last_mid    = mid;
      if (it.first_byte) check_byte = plain;
      else body_sum = body_sum + plain;
      r.plain_byte  = plain;
      r.is_checksum = it.first_byte;
      r.is_last     = it.last_byte;
      r.checksum_ok = it.last_byte && (body_sum == check_byte);
      expected_plain_q.push_back(r);
    endfunction

    function void check_plain(cxpd_pkg::result_t got);
      cxpd_pkg::result_t want;
      if (expected_plain_q.size() == 0) begin
        $error("result with no pending byte: plain_byte %02h", got.plain_byte);
        errors++;
        return;
      end
      want = expected_plain_q.pop_front();
      results_seen++;
      if (want.is_last) begin
        if (want.checksum_ok) sums_matched++;
        else sums_missed++;
      end
      if (got.plain_byte !== want.plain_byte) begin
        $error("plain_byte mismatch: expected %02h, actual %02h",
               want.plain_byte, got.plain_byte);
        errors++;
      end
      if (got.is_checksum !== want.is_checksum) begin
        $error("is_checksum mismatch: expected %0b, actual %0b",
               want.is_checksum, got.is_checksum);
        errors++;
      end
      if (got.is_last !== want.is_last) begin
        $error("is_last mismatch: expected %0b, actual %0b", want.is_last, got.is_last);
        errors++;
      end
      if (got.checksum_ok !== want.checksum_ok) begin
        $error("checksum_ok mismatch: expected %0b, actual %0b",
               want.checksum_ok, got.checksum_ok);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_plain_q.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] cipher_byte_i;
  logic [7:0] random_key_i;
  logic       first_byte_i;
  logic       last_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] plain_byte_o;
  logic       is_checksum_o;
  logic       is_last_o;
  logic       checksum_ok_o;

  decrypt_predictor pred = new();

  int unsigned cycle_cnt;
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned keys_written;
  bit          idle_enabled;

  // Encoder state used only to build well-formed packets; it is the
  // inverse of the decrypt chain and restarts on every packet start.
  logic [7:0] enc_key;
  logic [7:0] enc_cipher;
  logic [7:0] enc_mid;
  logic [7:0] enc_pos;

  chained_xor_packet_decrypt dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cipher_byte_i (cipher_byte_i),
    .random_key_i  (random_key_i),
    .first_byte_i  (first_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .plain_byte_o  (plain_byte_o),
    .is_checksum_o (is_checksum_o),
    .is_last_o     (is_last_o),
    .checksum_ok_o (checksum_ok_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // Abort the run if it hangs anywhere.
  initial begin : watchdog
    while (cycle_cnt < CycleLimit) @(posedge clk_i);
    $display("chained_xor_packet_decrypt verification failed");
    $finish;
  end

  // Result side: check every transaction, then pick the next ready value.
  // Switch between stall patterns on a tick counter so stalls land on all
  // phases of the pipeline; mode 0 gives stretches with no stalls at all.
  int unsigned rx_mode;
  int unsigned rx_tick;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      pred.check_plain('{plain_byte:  plain_byte_o,
                         is_checksum: is_checksum_o,
                         is_last:     is_last_o,
                         checksum_ok: checksum_ok_o});
    end
    rx_tick <= rx_tick + 1;
    if (rx_tick % 48 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= (rx_tick % 8 >= 5);
    endcase
  end

  function automatic logic [7:0] rand_byte();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Encrypt one plain byte with the encoder chain and return the cipher.
  function automatic logic [7:0] seal_byte(input logic [7:0] plain, input logic [7:0] rk,
                                           input logic f);
    logic [7:0] mid;
    logic [7:0] c;
    if (f) begin
      enc_pos    = cxpd_pkg::FirstPosition;
      enc_cipher = '0;
      enc_mid    = '0;
    end else begin
      enc_pos = enc_pos + 8'd1;
    end
    mid        = plain ^ (enc_mid + rk + enc_pos);
    c          = mid ^ (enc_cipher + enc_key + enc_pos);
    enc_cipher = c;
    enc_mid    = mid;
    return c;
  endfunction

  // Present one byte and hold it until the transaction completes. When the
  // current burst runs out, first insert a random gap if idles are enabled.
  task automatic push_byte(input logic [7:0] c, input logic [7:0] rk,
                           input logic f, input logic l);
    int unsigned     gap;
    cxpd_pkg::item_t it;
    if (burst_left == 0) begin
      gap = idle_enabled ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    cipher_byte_i <= c;
    random_key_i  <= rk;
    first_byte_i  <= f;
    last_byte_i   <= l;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    it.cipher_byte = c;
    it.random_key  = rk;
    it.first_byte  = f;
    it.last_byte   = l;
    pred.note_cipher(it);
    items_sent++;
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pred.pending() != 0) @(posedge clk_i);
  endtask

  // Write the private key with the block idle.
  task automatic write_key(input logic [7:0] k);
    drain();
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= k;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pred.set_key(k);
    enc_key = k;
    keys_written++;
  endtask

  // Send one packet region: checksum byte then payload. Optionally corrupt
  // the checksum, leave the packet open, or swap the random key halfway.
  task automatic send_packet(input int unsigned len, input bit corrupt,
                             input bit drop_last, input bit rk_change);
    logic [7:0] body [$];
    logic [7:0] rk;
    logic [7:0] chk;
    logic [7:0] b;
    logic       close;
    chk = '0;
    rk  = rand_byte();
    for (int unsigned i = 0; i < len; i++) begin
      b = rand_byte();
      body.push_back(b);
      chk = chk + b;
    end
    if (corrupt) chk = chk + 8'($urandom_range(1, 255));
    close = !drop_last;
    push_byte(seal_byte(chk, rk, 1'b1), rk, 1'b1, close && (len == 0));
    for (int unsigned i = 0; i < len; i++) begin
      if (rk_change && i == len / 2) rk = rand_byte();
      push_byte(seal_byte(body[i], rk, 1'b0), rk, 1'b0, close && (i == len - 1));
    end
  endtask

  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 4);
    repeat (n) push_byte(rand_byte(), rand_byte(), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
  endtask

  // Pick one random stimulus unit: mostly well-formed packets.
  task automatic send_random_unit();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    len  = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    if (pick < 65) send_packet(len, 1'b0, 1'b0, 1'b0);
    else if (pick < 75) send_packet(len, 1'b1, 1'b0, 1'b0);
    else if (pick < 80) send_packet(len, 1'b0, 1'b1, 1'b0);
    else if (pick < 85) send_packet(len, 1'b0, 1'b0, 1'b1);
    else send_noise();
  endtask

  initial begin : stimulus
    logic [7:0]  key_val;
    int unsigned phase_start;
    int unsigned wait_cnt;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    cipher_byte_i <= '0;
    random_key_i  <= '0;
    first_byte_i  <= 1'b0;
    last_byte_i   <= 1'b0;
    items_sent    = 0;
    burst_left    = 0;
    keys_written  = 0;
    idle_enabled  = 1'b1;
    enc_key       = cxpd_pkg::PrivateKeyReset;
    enc_cipher    = '0;
    enc_mid       = '0;
    enc_pos       = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bytes with no packet start, right after reset.
    push_byte(8'h00, 8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 8'hFF, 1'b0, 1'b1);

    write_key(8'hFF);
    // Empty payloads: a zero checksum matches, a nonzero one does not.
    push_byte(seal_byte(8'h00, 8'hA5, 1'b1), 8'hA5, 1'b1, 1'b1);
    push_byte(seal_byte(8'h5A, 8'h00, 1'b1), 8'h00, 1'b1, 1'b1);
    send_packet(3, 1'b0, 1'b0, 1'b0);
    send_packet(5, 1'b0, 1'b0, 1'b1);
    // Continue the chain after a last byte with no new start.
    push_byte(8'h00, 8'hFF, 1'b0, 1'b0);
    push_byte(8'hFF, 8'h00, 1'b0, 1'b1);
    send_packet(4, 1'b1, 1'b0, 1'b0);
    push_byte(8'hFF, 8'hFF, 1'b1, 1'b1);

    // Random phases, each under its own private key.
    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      if (phase == 0) key_val = 8'h00;
      else if (phase == 1) key_val = 8'hFF;
      else key_val = 8'($urandom_range(0, 255));
      write_key(key_val);
      idle_enabled = (phase != 1);
      phase_start  = items_sent;
      // Wrap the position counter with one long packet.
      if (phase == 3) send_packet($urandom_range(260, 300), 1'b0, 1'b0, 1'b0);
      while (items_sent - phase_start < PhaseItems) begin
        send_random_unit();
        if (phase == 2 && items_sent - phase_start >= PhaseItems / 2 &&
            items_sent - phase_start < PhaseItems / 2 + 12) begin
          drain();
        end
      end
    end
    in_valid_i <= 1'b0;

    // Wait for the tail, bounded, then let the pipeline settle.
    wait_cnt = 0;
    while (pred.pending() != 0 && wait_cnt < DrainLimit) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (pred.pending() != 0) begin
      $error("%0d results never arrived", pred.pending());
      pred.errors++;
    end

    $display("Covered %0d bytes (%0d packet starts) over %0d private key settings.",
             items_sent, pred.starts_seen, keys_written);
    $display("Closing sums: %0d matched the checksum, %0d did not.",
             pred.sums_matched, pred.sums_missed);
    if (pred.errors == 0) begin
      $display("chained_xor_packet_decrypt verification clean");
    end else begin
      $display("chained_xor_packet_decrypt verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/cxpd_pkg.sv
hw/rtl/cxpd_in_reg.sv
hw/rtl/cxpd_decrypt.sv
hw/rtl/chained_xor_packet_decrypt.sv
dv/tb_chained_xor_packet_decrypt.sv
